@@ rtl/chps_pkg.sv @@
// shared types and constants for the coin hopper payout sequencer
package chps_pkg;

  localparam int REG_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int COUNT_W          = 3;
  localparam int EVENT_W          = 4;
  localparam int DELAY_BITS_DFLT  = 16;
  localparam int STOP_TICKS       = 10;

  localparam logic [REG_W-1:0] PAYOUT_POLL_RST = 16'd100;
  localparam logic [REG_W-1:0] COIN_POLL_RST   = 16'd10;
  localparam logic [REG_W-1:0] DEBOUNCE_RST    = 16'd50;

  localparam logic [COUNT_W-1:0] PAY_TWO   = 3'd2;
  localparam logic [COUNT_W-1:0] PAY_THREE = 3'd3;
  localparam logic [COUNT_W-1:0] PAY_FOUR  = 3'd4;
  localparam logic [COUNT_W-1:0] PAY_SEVEN = 3'd7;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAYOUT_POLL = 2'd0,
    REG_COIN_POLL   = 2'd1,
    REG_DEBOUNCE    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HOMING  = 3'd0,
    PH_IDLE    = 3'd1,
    PH_COIN    = 3'd2,
    PH_PAY     = 3'd3,
    PH_RELEASE = 3'd4,
    PH_STOP    = 3'd5
  } phase_t;

  // one sampled tick of the pins, all active low
  typedef struct packed {
    logic pay_two_level;
    logic pay_three_level;
    logic pay_four_level;
    logic pay_seven_level;
    logic coin_exit_level;
    logic hopper_level;
  } tick_t;

endpackage

@@ rtl/chps_if.sv @@
// stream and configuration interfaces of the payout sequencer

interface chps_tick_if;
  logic valid;
  logic ready;
  logic pay_two_level;
  logic pay_three_level;
  logic pay_four_level;
  logic pay_seven_level;
  logic coin_exit_level;
  logic hopper_level;

  modport source (output valid, pay_two_level, pay_three_level, pay_four_level,
                  pay_seven_level, coin_exit_level, hopper_level, input ready);
  modport sink   (input valid, pay_two_level, pay_three_level, pay_four_level,
                  pay_seven_level, coin_exit_level, hopper_level, output ready);
endinterface

interface chps_result_if;
  logic              valid;
  logic              ready;
  logic              motor_on;
  logic [2:0]        shown_count;
  logic              event_valid;
  logic signed [3:0] event_value;

  modport source (output valid, motor_on, shown_count, event_valid, event_value,
                  input ready);
  modport sink   (input valid, motor_on, shown_count, event_valid, event_value,
                  output ready);
endinterface

interface chps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/coin_hopper_payout_sequencer.sv @@
// top level of the coin hopper payout sequencer
//
//  channel  | role   | payload
//  ---------+--------+-----------------------------------------------------
//  tick     | sink   | four payout pins, coin exit and hopper levels
//  result   | source | motor_on, shown_count, event_valid, event_value
//  cfg      | sink   | register index and 16-bit write data
//
// one result per tick; a tick transfer lands in an input register and is
// processed from there into the result register, so a tick can be taken
// every cycle when the result side keeps up
// the result register parts the two sides: a stalled result holds the
// input register, and tick ready drops only when both are full
// rst is synchronous, active high; after reset the motor runs (homing)
// cfg is always ready; an accepted write goes straight into its register
module coin_hopper_payout_sequencer
  import chps_pkg::*;
#(
  parameter int DELAY_BITS = DELAY_BITS_DFLT
) (
  input  logic  clk,
  input  logic  rst,
  chps_tick_if.sink     tick,
  chps_result_if.source result,
  chps_cfg_if.sink      cfg
);

  // configuration registers
  logic [REG_W-1:0] payout_poll_ticks;
  logic [REG_W-1:0] coin_exit_poll_ticks;
  logic [REG_W-1:0] hopper_debounce_ticks;

  // input register
  logic  tick_valid;
  tick_t tick_q;

  // sequencer state
  phase_t              phase, phase_next;
  logic [COUNT_W-1:0]  coins_left, coins_left_next;
  logic [DELAY_BITS-1:0] wait_count, wait_count_next;
  logic [COUNT_W-1:0]  display_value, display_value_next;
  logic                motor_flag, motor_flag_next;

  // result register
  logic                out_valid;
  logic                out_motor;
  logic [COUNT_W-1:0]  out_count;
  logic                out_ev_valid;
  logic [EVENT_W-1:0]  out_ev_value;

  logic               ev_valid;
  logic [EVENT_W-1:0] ev_value;
  logic               step;
  logic [COUNT_W-1:0] payout;
  logic [DELAY_BITS-1:0] wait_dec;
  logic [DELAY_BITS-1:0] poll_load;
  logic [DELAY_BITS-1:0] coin_load;
  logic [DELAY_BITS-1:0] debounce_load;
  logic [COUNT_W-1:0]  coins_dec;

  // clamp a register value into the wait counter
  function automatic logic [DELAY_BITS-1:0] sat_load(input logic [REG_W-1:0] v);
    logic [DELAY_BITS-1:0] r;
    if (DELAY_BITS >= REG_W) begin
      r = DELAY_BITS'(v);
    end else if ((v >> DELAY_BITS) != '0) begin
      r = '1;
    end else begin
      r = DELAY_BITS'(v);
    end
    return r;
  endfunction

  // an interval of n gives a reload of n-1 so polls fall every n ticks
  function automatic logic [DELAY_BITS-1:0] interval_load(input logic [REG_W-1:0] v);
    logic [DELAY_BITS-1:0] r;
    if (v == '0) begin
      r = '0;
    end else begin
      r = sat_load(v - REG_W'(1));
    end
    return r;
  endfunction

  // processing step fires when the input register holds a tick and the result register is free or draining
  assign step       = tick_valid && (!out_valid || result.ready);
  assign tick.ready = !tick_valid || step;
  assign cfg.ready  = 1'b1;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      payout_poll_ticks     <= PAYOUT_POLL_RST;
      coin_exit_poll_ticks  <= COIN_POLL_RST;
      hopper_debounce_ticks <= DEBOUNCE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PAYOUT_POLL: payout_poll_ticks     <= cfg.data;
        REG_COIN_POLL:   coin_exit_poll_ticks  <= cfg.data;
        REG_DEBOUNCE:    hopper_debounce_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_q.pay_two_level   <= tick.pay_two_level;
      tick_q.pay_three_level <= tick.pay_three_level;
      tick_q.pay_four_level  <= tick.pay_four_level;
      tick_q.pay_seven_level <= tick.pay_seven_level;
      tick_q.coin_exit_level <= tick.coin_exit_level;
      tick_q.hopper_level    <= tick.hopper_level;
    end
  end

  // shared pieces of the step
  always_comb begin
    payout = '0;
    if (!tick_q.pay_two_level)   payout = PAY_TWO;
    if (!tick_q.pay_three_level) payout = PAY_THREE;
    if (!tick_q.pay_four_level)  payout = PAY_FOUR;
    if (!tick_q.pay_seven_level) payout = PAY_SEVEN;
  end

  assign wait_dec      = wait_count - DELAY_BITS'(1);
  assign coins_dec     = coins_left - COUNT_W'(1);
  assign poll_load     = interval_load(payout_poll_ticks);
  assign coin_load     = interval_load(coin_exit_poll_ticks);
  assign debounce_load = sat_load(hopper_debounce_ticks);

  // next state
  always_comb begin
    phase_next         = phase;
    coins_left_next    = coins_left;
    wait_count_next    = wait_count;
    display_value_next = display_value;
    motor_flag_next    = motor_flag;
    case (phase)
      PH_HOMING: begin
        // run until the hopper switch is seen open
        if (tick_q.hopper_level) begin
          motor_flag_next = 1'b0;
          phase_next      = PH_IDLE;
          wait_count_next = '0;
        end else begin
          motor_flag_next = 1'b1;
        end
      end
      PH_COIN: begin
        if (wait_count != '0) begin
          wait_count_next = wait_dec;
        end else if (!tick_q.coin_exit_level) begin
          motor_flag_next = 1'b1;
          phase_next      = PH_PAY;
          wait_count_next = '0;
        end else begin
          wait_count_next = coin_load;
        end
      end
      PH_PAY: begin
        // count hopper closures, debounce all but the last coin
        if (wait_count != '0) begin
          wait_count_next = wait_dec;
        end else if (!tick_q.hopper_level) begin
          coins_left_next    = coins_dec;
          display_value_next = coins_dec;
          if (coins_dec == '0) begin
            phase_next = PH_RELEASE;
          end else begin
            wait_count_next = debounce_load;
          end
        end
      end
      PH_RELEASE: begin
        if (tick_q.hopper_level) begin
          phase_next      = PH_STOP;
          wait_count_next = DELAY_BITS'(STOP_TICKS);
        end
      end
      PH_STOP: begin
        // motor overrun, then back to idle polling
        if (wait_count != '0) begin
          wait_count_next = wait_dec;
        end
        if (wait_count == '0 || wait_dec == '0) begin
          motor_flag_next = 1'b0;
          phase_next      = PH_IDLE;
          wait_count_next = poll_load;
        end
      end
      default: begin
        // idle, and any unused code behaves as idle
        phase_next = PH_IDLE;
        if (wait_count != '0) begin
          wait_count_next = wait_dec;
        end else if (payout != '0) begin
          coins_left_next    = payout;
          display_value_next = payout;
          phase_next         = PH_COIN;
          wait_count_next    = '0;
        end else begin
          wait_count_next = poll_load;
        end
      end
    endcase
  end

  // bookkeeping event of this tick
  always_comb begin
    ev_valid = 1'b0;
    ev_value = '0;
    case (phase)
      PH_COIN: begin
        if (wait_count == '0 && !tick_q.coin_exit_level) begin
          ev_valid = 1'b1;
          ev_value = EVENT_W'(1);
        end
      end
      PH_HOMING, PH_PAY, PH_RELEASE, PH_STOP: begin
        ev_valid = 1'b0;
      end
      default: begin
        // payout start: minus the payout
        if (wait_count == '0 && payout != '0) begin
          ev_valid = 1'b1;
          ev_value = EVENT_W'(0) - EVENT_W'(payout);
        end
      end
    endcase
  end

  // state registers, advanced once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HOMING;
      coins_left    <= '0;
      wait_count    <= '0;
      display_value <= '0;
      motor_flag    <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      coins_left    <= coins_left_next;
      wait_count    <= wait_count_next;
      display_value <= display_value_next;
      motor_flag    <= motor_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_motor    <= motor_flag_next;
      out_count    <= display_value_next;
      out_ev_valid <= ev_valid;
      out_ev_value <= ev_value;
    end
  end

  assign result.valid       = out_valid;
  assign result.motor_on    = out_motor;
  assign result.shown_count = out_count;
  assign result.event_valid = out_ev_valid;
  assign result.event_value = signed'(out_ev_value);

endmodule
